### design/pdrl_pkg.sv
// Package for the pointer delta rate limiter.
// Holds field widths, register and item-kind codes, the slot types and the saturation helpers.
// No dependencies.
package pdrl_pkg;

    localparam int MAX_CODES_DEF = 4;
    localparam int SLOT_CAP      = 4;

    localparam int TYPE_W     = 8;
    localparam int CODE_W     = 16;
    localparam int VALUE_W    = 32;
    localparam int REM_W      = 16;
    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 16;
    localparam int COUNT_W    = 3;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [FUNC_W-1:0]    t_func;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Item kinds carried on tuser
    localparam t_func FUNC_EVENT      = 2'd0;
    localparam t_func FUNC_TICK       = 2'd1;
    localparam t_func FUNC_SET_ACTIVE = 2'd2;

    // Configuration register indexes
    localparam t_cfg_idx CFG_EVENT_TYPE = 3'd0;
    localparam t_cfg_idx CFG_DELAY      = 3'd1;
    localparam t_cfg_idx CFG_CODE_COUNT = 3'd2;
    localparam t_cfg_idx CFG_CODE_0     = 3'd3;

    localparam logic [TYPE_W-1:0]  RST_EVENT_TYPE = 8'd2;
    localparam logic [DELAY_W-1:0] RST_DELAY      = 16'd8;

    typedef struct packed {
        logic signed [REM_W-1:0] rem;
        logic                    held;
        logic [TIME_W-1:0]       last;
    } t_slot;

    typedef struct packed {
        logic                      absorb;
        logic signed [VALUE_W-1:0] value;
        logic                      sync;
        t_slot                     slot_next;
    } t_calc;

    function automatic logic signed [REM_W-1:0] sat_rem(input logic signed [VALUE_W:0] v);
        logic signed [VALUE_W:0] lo;
        logic signed [VALUE_W:0] hi;
        lo = -(33'sd1 <<< (REM_W - 1));
        hi = (33'sd1 <<< (REM_W - 1)) - 33'sd1;
        if (v < lo) begin
            return lo[REM_W-1:0];
        end else if (v > hi) begin
            return hi[REM_W-1:0];
        end
        return v[REM_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [VALUE_W:0] v);
        // Overflow shows as the two top bits disagreeing
        if (v[VALUE_W] != v[VALUE_W-1]) begin
            return v[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        end
        return v[VALUE_W-1:0];
    endfunction

endpackage

### design/pointer_delta_rate_limiter.sv
// Top level of the pointer delta rate limiter.
// Depends on pdrl_pkg, pdrl_match and pdrl_calc.
//
// Takes one item per cycle while the result side does not stall: an item is captured in an
// input register, decided against the slot state once the result register can advance, and
// written to the result register. Ticks and set-active items update state and give no result.
// The input register can still take an item while a result waits, and both halt only when the
// result register and the input register are full. Configuration is always ready and must
// only be written while the block is idle.
module pointer_delta_rate_limiter
    import pdrl_pkg::*;
#(
    parameter int MAX_CODES = MAX_CODES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // ev_type[7:0], ev_code[23:8], ev_value[55:24],
                                                 // active_flag[56], zero[63:57]
    input  logic                  s_axis_tlast,  // ev_sync
    input  logic [FUNC_W-1:0]     s_axis_tuser,  // func[1:0]
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // out_value[31:0]
    output logic                  m_axis_tlast,  // out_sync
    output logic                  m_axis_tuser,  // verdict
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;

    // Configuration
    logic [TYPE_W-1:0]  r_event_type;
    logic [DELAY_W-1:0] r_delay;
    logic [COUNT_W-1:0] r_code_count;
    logic [CODE_W-1:0]  r_code [MAX_CODES];

    // Block state
    t_slot             r_slot [MAX_CODES];
    logic [TIME_W-1:0] r_now;
    logic              r_active;

    // Input register
    logic                      r_in_valid;
    t_func                     r_in_func;
    logic [TYPE_W-1:0]         r_in_type;
    logic [CODE_W-1:0]         r_in_code;
    logic signed [VALUE_W-1:0] r_in_value;
    logic                      r_in_sync;
    logic                      r_in_flag;

    // Result register
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_sync;
    logic                      r_out_verdict;

    logic             advance;
    logic             proc;
    logic             match_en;
    logic             hit;
    logic [IDX_W-1:0] idx;
    t_calc            calc;

    assign o_cfg_ready   = 1'b1;
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign proc          = r_in_valid && advance;
    assign match_en      = r_active && (r_in_type == r_event_type);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tlast  = r_out_sync;
    assign m_axis_tuser  = r_out_verdict;

    pdrl_match #(
        .MAX_CODES (MAX_CODES),
        .IDX_W     (IDX_W)
    ) u_match (
        .i_codes      (r_code),
        .i_code_count (r_code_count),
        .i_enable     (match_en),
        .i_ev_code    (r_in_code),
        .o_hit        (hit),
        .o_idx        (idx)
    );

    pdrl_calc #(
        .MAX_CODES (MAX_CODES)
    ) u_calc (
        .i_slot  (r_slot[idx]),
        .i_value (r_in_value),
        .i_sync  (r_in_sync),
        .i_now   (r_now),
        .i_delay (r_delay),
        .o_calc  (calc)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_type <= RST_EVENT_TYPE;
            r_delay      <= RST_DELAY;
            r_code_count <= '0;
            for (int k = 0; k < MAX_CODES; k++) begin
                r_code[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EVENT_TYPE: r_event_type <= i_cfg_data[TYPE_W-1:0];
                CFG_DELAY:      r_delay      <= i_cfg_data[DELAY_W-1:0];
                CFG_CODE_COUNT: r_code_count <= i_cfg_data[COUNT_W-1:0];
                default: begin
                    // Code slots beyond MAX_CODES are never looked at; drop those writes
                    for (int k = 0; k < MAX_CODES; k++) begin
                        if (i_cfg_index == CFG_IDX_W'(int'(CFG_CODE_0) + k)) begin
                            r_code[k] <= i_cfg_data[CODE_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // Input register: capture a transaction whenever the register is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func  <= s_axis_tuser;
            r_in_type  <= s_axis_tdata[7:0];
            r_in_code  <= s_axis_tdata[23:8];
            r_in_value <= s_axis_tdata[55:24];
            r_in_sync  <= s_axis_tlast;
            r_in_flag  <= s_axis_tdata[56];
        end
    end

    // Block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_active <= 1'b1;
            for (int k = 0; k < MAX_CODES; k++) begin
                r_slot[k] <= '0;
            end
        end else if (proc) begin
            if (r_in_func == FUNC_TICK) begin
                r_now <= r_now + 1'b1;
            end else if (r_in_func == FUNC_SET_ACTIVE) begin
                r_active <= r_in_flag;
                if (!r_in_flag) begin
                    for (int k = 0; k < MAX_CODES; k++) begin
                        r_slot[k].rem  <= '0;
                        r_slot[k].held <= 1'b0;
                        r_slot[k].last <= r_now;
                    end
                end
            end else if (r_in_func == FUNC_EVENT && hit) begin
                r_slot[idx] <= calc.slot_next;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= proc && (r_in_func == FUNC_EVENT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && (r_in_func == FUNC_EVENT)) begin
            if (hit) begin
                r_out_value   <= calc.value;
                r_out_sync    <= calc.sync;
                r_out_verdict <= calc.absorb;
            end else begin
                r_out_value   <= r_in_value;
                r_out_sync    <= r_in_sync;
                r_out_verdict <= 1'b0;
            end
        end
    end

endmodule

### design/pdrl_match.sv
// Slot lookup for the pointer delta rate limiter: lowest slot whose code matches wins.
// Depends on pdrl_pkg.
module pdrl_match
    import pdrl_pkg::*;
#(
    parameter int MAX_CODES = MAX_CODES_DEF,
    parameter int IDX_W     = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1
) (
    input  logic [CODE_W-1:0]  i_codes [MAX_CODES],
    input  logic [COUNT_W-1:0] i_code_count,
    input  logic               i_enable,
    input  logic [CODE_W-1:0]  i_ev_code,
    output logic               o_hit,
    output logic [IDX_W-1:0]   o_idx
);

    always_comb begin
        o_hit = 1'b0;
        o_idx = '0;
        // Walk downwards so the lowest matching slot is the one left standing
        for (int i = MAX_CODES - 1; i >= 0; i--) begin
            if (i_enable && (i_code_count > COUNT_W'(i)) && (i_codes[i] == i_ev_code)) begin
                o_hit = 1'b1;
                o_idx = IDX_W'(i);
            end
        end
    end

endmodule

### design/pdrl_calc.sv
// Per-slot decision for the pointer delta rate limiter: expire, hold back or flush.
// Depends on pdrl_pkg.
module pdrl_calc
    import pdrl_pkg::*;
#(
    parameter int MAX_CODES = MAX_CODES_DEF
) (
    input  t_slot                     i_slot,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_sync,
    input  logic [TIME_W-1:0]         i_now,
    input  logic [DELAY_W-1:0]        i_delay,
    output t_calc                     o_calc
);

    localparam int LIM_W = DELAY_W + $clog2(MAX_CODES + 1);

    logic [TIME_W-1:0]       dt;
    logic [LIM_W-1:0]        lim;
    logic                    expire;
    logic                    hold;
    logic signed [REM_W-1:0] rem_eff;
    logic                    held_eff;
    logic signed [VALUE_W:0] sum;

    always_comb begin
        dt       = i_now - i_slot.last;
        lim      = LIM_W'(i_delay) * LIM_W'(MAX_CODES);
        expire   = dt >= TIME_W'(lim);
        hold     = dt < TIME_W'(i_delay);
        rem_eff  = expire ? '0 : i_slot.rem;
        held_eff = expire ? 1'b0 : i_slot.held;
        sum      = $signed({i_value[VALUE_W-1], i_value}) + (VALUE_W + 1)'(rem_eff);

        if (hold) begin
            o_calc.absorb         = 1'b1;
            o_calc.value          = '0;
            o_calc.sync           = 1'b0;
            o_calc.slot_next.rem  = sat_rem(sum);
            o_calc.slot_next.held = held_eff | i_sync;
            o_calc.slot_next.last = i_slot.last;
        end else begin
            o_calc.absorb         = 1'b0;
            o_calc.value          = sat_value(sum);
            o_calc.sync           = i_sync | held_eff;
            o_calc.slot_next.rem  = '0;
            o_calc.slot_next.held = 1'b0;
            o_calc.slot_next.last = i_now;
        end
    end

endmodule

### design/pdrl_checker.sv
// Port-level checks for the pointer delta rate limiter, bound to the top level.
// Depends on pointer_delta_rate_limiter's ports only.
module pdrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // An absorbed event carries neither value nor sync
    a_absorbed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 32'd0) && !m_axis_tlast)
        else $error("absorbed event carries data");

    // Input side never stalls while the result side drains
    a_no_false_stall: assert property (@(posedge i_clk)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while result side ready");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind pointer_delta_rate_limiter pdrl_checker u_pdrl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
